@@ hw/rtl/esc_key_pkg.sv @@
// Package with parse phases, key kinds and character constants for the escape key decoder.
`timescale 1ns / 1ps

package esc_key_pkg;

  // Parser position inside an escape sequence.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_SS3   = 3'd3,
    PH_DIGIT = 3'd4,
    PH_SEMI  = 3'd5,
    PH_MOD   = 3'd6
  } phase_t;

  // Modifier class that was seen after "ESC [ 1 ;".
  typedef enum logic [1:0] {
    MOD_SHIFT      = 2'd0,
    MOD_CTRL       = 2'd1,
    MOD_CTRL_SHIFT = 2'd2
  } mod_class_t;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Key kind codes on the result channel.
  localparam logic [4:0] K_CHAR     = 5'd0;
  localparam logic [4:0] K_ESC      = 5'd1;
  localparam logic [4:0] K_DEL      = 5'd2;
  localparam logic [4:0] K_PGUP     = 5'd3;
  localparam logic [4:0] K_PGDN     = 5'd4;
  localparam logic [4:0] K_UP       = 5'd5;
  localparam logic [4:0] K_HOME     = 5'd9;
  localparam logic [4:0] K_END      = 5'd10;
  localparam logic [4:0] K_MOD_BASE = 5'd11;
  localparam logic [4:0] K_MAX      = 5'd22;

  // Character bytes that the parser looks for.
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_F     = 8'h46;

  // Timeout register width and reset value.
  localparam int unsigned TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

endpackage

@@ hw/rtl/escape_sequence_key_decoder_core.sv @@
// Top level of the escape sequence key decoder: parser state, timeout counter and result register.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one transaction per byte or
// time tick: cmd 0 delivers rx_byte, cmd 1 is one tick. Each transaction
// yields zero or one key on the output channel (out_valid/out_ready) as
// key_kind and char_code. Plain bytes pass through as kind 0; escape
// sequences for arrows, Home, End, Delete, PageUp, PageDown and modified
// arrows become their key codes; an unknown or timed-out sequence gives ESC.
// A key appears in the output register on the cycle after its input
// transaction. Throughput is one transaction per cycle while not stalled.
// The parser step is one pass of compare logic into the result register.
// The cfg channel writes timeout_ticks (reset 100); it is always ready and
// should only be written while the decoder is idle.
// Reset (rst, synchronous) returns the parser to idle, clears the tick
// count and empties the output register. When the receiver stalls with a
// key held, in_ready drops until that key is taken; otherwise input keeps
// flowing even while the output register holds a key that is leaving.
module escape_sequence_key_decoder_core
  import esc_key_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [7:0]           rx_byte,
  // Output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           key_kind,
  output logic [7:0]           char_code
);

  // Architectural state.
  logic [TIMEOUT_W-1:0] timeout_ticks;
  phase_t               phase, phase_next;
  logic [7:0]           held_digit, held_digit_next;
  mod_class_t           mod_class, mod_class_next;
  logic [TIMEOUT_W-1:0] tick_count, tick_count_next;

  // Result of the current step.
  logic       res_valid;
  logic [4:0] res_kind;
  logic [7:0] res_code;

  logic                 in_fire;
  logic [TIMEOUT_W-1:0] tick_limit;
  logic [TIMEOUT_W-1:0] tick_inc;
  logic                 is_arrow;
  logic [7:0]           arrow_diff;
  logic [1:0]           arrow_idx;
  logic                 is_digit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Byte classification shared by several phases.
  assign is_arrow   = (rx_byte >= CH_A) && (rx_byte <= CH_D);
  assign arrow_diff = rx_byte - CH_A;
  assign arrow_idx  = arrow_diff[1:0];
  assign is_digit   = (rx_byte >= CH_0) && (rx_byte <= CH_9);

  // A zero timeout behaves like one tick; the count saturates at all ones.
  assign tick_limit = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
  assign tick_inc   = (tick_count == '1) ? tick_count : tick_count + TIMEOUT_W'(1);

  // Parser step: next state and the key, if any, for one transaction.
  always_comb begin
    phase_next      = phase;
    held_digit_next = held_digit;
    mod_class_next  = mod_class;
    tick_count_next = tick_count;
    res_valid       = 1'b0;
    res_kind        = K_ESC;
    res_code        = 8'd0;

    if (cmd == CMD_TICK) begin
      if (phase != PH_IDLE) begin
        tick_count_next = tick_inc;
        if (tick_inc >= tick_limit) begin
          res_valid = 1'b1;
          res_kind  = K_ESC;
          res_code  = CH_ESC;
        end
      end
    end else begin
      tick_count_next = '0;
      // Any key out of a sequence ends it; plain ESC is the fallback.
      res_valid = 1'b1;
      res_kind  = K_ESC;
      res_code  = CH_ESC;
      case (phase)
        PH_IDLE: begin
          if (rx_byte == CH_ESC) begin
            res_valid = 1'b0;
          end else begin
            res_kind = K_CHAR;
            res_code = rx_byte;
          end
        end
        PH_ESC: begin
          if (rx_byte == CH_LBRKT || rx_byte == CH_O) begin
            res_valid = 1'b0;
          end
        end
        PH_CSI: begin
          if (is_digit) begin
            res_valid = 1'b0;
          end else if (is_arrow) begin
            res_kind = K_UP + {3'd0, arrow_idx};
            res_code = 8'd0;
          end else if (rx_byte == CH_H) begin
            res_kind = K_HOME;
            res_code = 8'd0;
          end else if (rx_byte == CH_F) begin
            res_kind = K_END;
            res_code = 8'd0;
          end
        end
        PH_SS3: begin
          if (rx_byte == CH_H) begin
            res_kind = K_HOME;
            res_code = 8'd0;
          end else if (rx_byte == CH_F) begin
            res_kind = K_END;
            res_code = 8'd0;
          end
        end
        PH_DIGIT: begin
          if (rx_byte == CH_TILDE) begin
            if (held_digit == CH_3) begin
              res_kind = K_DEL;
              res_code = 8'd0;
            end else if (held_digit == CH_5) begin
              res_kind = K_PGUP;
              res_code = 8'd0;
            end else if (held_digit == CH_6) begin
              res_kind = K_PGDN;
              res_code = 8'd0;
            end
          end else if (rx_byte == CH_SEMI && held_digit == CH_1) begin
            res_valid = 1'b0;
          end
        end
        PH_SEMI: begin
          if (rx_byte == CH_2 || rx_byte == CH_5 || rx_byte == CH_6) begin
            res_valid = 1'b0;
          end
        end
        PH_MOD: begin
          if (is_arrow && mod_class != 2'd3) begin
            res_kind = K_MOD_BASE + {1'b0, mod_class, 2'b00} + {3'd0, arrow_idx};
            res_code = 8'd0;
          end
        end
        default: begin
        end
      endcase

      // Advance the phase while the sequence is still open.
      if (!res_valid) begin
        case (phase)
          PH_IDLE: phase_next = PH_ESC;
          PH_ESC:  phase_next = (rx_byte == CH_LBRKT) ? PH_CSI : PH_SS3;
          PH_CSI: begin
            phase_next      = PH_DIGIT;
            held_digit_next = rx_byte;
          end
          PH_DIGIT: phase_next = PH_SEMI;
          PH_SEMI: begin
            phase_next = PH_MOD;
            if (rx_byte == CH_2) begin
              mod_class_next = MOD_SHIFT;
            end else if (rx_byte == CH_5) begin
              mod_class_next = MOD_CTRL;
            end else begin
              mod_class_next = MOD_CTRL_SHIFT;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    // Every key ends the sequence and clears the parser.
    if (res_valid) begin
      phase_next      = PH_IDLE;
      held_digit_next = 8'd0;
      mod_class_next  = MOD_SHIFT;
      tick_count_next = '0;
    end
  end

  // Timeout configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Parser state registers advance on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'd0;
      mod_class  <= MOD_SHIFT;
      tick_count <= '0;
    end else if (in_fire) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
      mod_class  <= mod_class_next;
      tick_count <= tick_count_next;
    end
  end

  // Output register: loads a key on an accepted transaction, drains on out_ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      key_kind  <= res_kind;
      char_code <= res_code;
    end
  end

  // A held key that is not taken must block new input.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while a stalled key is held");

  // The tick count is always zero outside a sequence.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0))
    else $error("tick count nonzero while idle");

  // A tick while idle leaves the parser idle and produces no key.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_TICK && phase == PH_IDLE) |=> (phase == PH_IDLE && !out_valid))
    else $error("idle tick changed state or produced a key");

  // Only plain characters and ESC carry a character code.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_kind != K_CHAR && key_kind != K_ESC) |-> (char_code == 8'd0))
    else $error("special key carries a character code");

  // Key kinds stay within the defined range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_kind <= K_MAX))
    else $error("key kind out of range");

endmodule
